### sv/pwmsc_pkg.sv
// pwmsc_pkg: shared widths, codes and the base decoder of the motif scanner
// no dependencies; compiled first

package pwmsc_pkg;

    localparam int MAX_MOTIF_LEN_DEF = 16;
    localparam int WEIGHT_BITS_DEF   = 24;
    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH       = 4;

    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int WPOS_W     = 4;
    localparam int BASE_W     = 2;
    localparam int WVAL_W     = 24;
    localparam int MLEN_W     = 5;
    localparam int SCORE_W    = 32;
    localparam int HPOS_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int KIND_W     = 2;

    localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;
    localparam logic [BASE_W-1:0] BASE_T = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCAN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] code;
    } t_base_dec;

    function automatic t_base_dec decode_base(input logic [CHAR_W-1:0] ch);
        t_base_dec d;
        d.ok   = 1'b1;
        d.code = BASE_A;
        case (ch)
            CHAR_A: d.code = BASE_A;
            CHAR_C: d.code = BASE_C;
            CHAR_G: d.code = BASE_G;
            CHAR_T: d.code = BASE_T;
            default: d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

### sv/pwmsc_if.sv
// pwmsc_if: valid/ready channels of the motif scanner (input, result, config)
// depends on pwmsc_pkg

interface pwmsc_in_if;
    import pwmsc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [CHAR_W-1:0]        base_char;
    logic [WPOS_W-1:0]        weight_pos;
    logic [BASE_W-1:0]        weight_base;
    logic signed [WVAL_W-1:0] weight_value;
    modport source (output valid, func, base_char, weight_pos, weight_base, weight_value,
                    input ready);
    modport sink (input valid, func, base_char, weight_pos, weight_base, weight_value,
                  output ready);
endinterface

interface pwmsc_out_if;
    import pwmsc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      is_error;
    logic [HPOS_W-1:0]         hit_position;
    logic signed [SCORE_W-1:0] hit_score;
    modport source (output valid, is_error, hit_position, hit_score, input ready);
    modport sink (input valid, is_error, hit_position, hit_score, output ready);
endinterface

interface pwmsc_cfg_if;
    import pwmsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/pwmsc_queue.sv
// pwmsc_queue: small register fifo between the front and back parts
// no package dependency

module pwmsc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_data[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

### sv/pwmsc_front.sv
// pwmsc_front: takes input words, decodes bases, keeps the window and count
// depends on pwmsc_pkg and pwmsc_if; feeds pwmsc_queue

module pwmsc_front #(
    parameter int MAX_MOTIF_LEN = pwmsc_pkg::MAX_MOTIF_LEN_DEF,
    parameter int WEIGHT_BITS   = pwmsc_pkg::WEIGHT_BITS_DEF,
    parameter int POSITION_BITS = pwmsc_pkg::POSITION_BITS_DEF,
    parameter int LEN_W         = $clog2(MAX_MOTIF_LEN + 1),
    parameter int ENTRY_W       = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pwmsc_in_if.sink           i_in,
    input  logic [LEN_W-1:0]   i_len,
    output logic               o_push,
    output logic [ENTRY_W-1:0] o_entry,
    input  logic               i_full
);
    import pwmsc_pkg::*;

    localparam int IDX_W = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int ABITS = IDX_W + BASE_W;
    localparam logic signed [32:0] WMAX =
        33'((longint'(1) <<< (WEIGHT_BITS - 1)) - longint'(1));
    localparam logic signed [32:0] WMIN = 33'(-(longint'(1) <<< (WEIGHT_BITS - 1)));

    typedef struct packed {
        logic [KIND_W-1:0]                     kind;
        logic [LEN_W-1:0]                      len;
        logic [HPOS_W-1:0]                     pos;
        logic [MAX_MOTIF_LEN-1:0][BASE_W-1:0] win;
        logic [ABITS-1:0]                      waddr;
        logic [WEIGHT_BITS-1:0]                wval;
    } t_entry;

    logic [MAX_MOTIF_LEN-1:0][BASE_W-1:0] r_win, n_win, win_sh;
    logic [POSITION_BITS-1:0]             r_seen, n_seen, seen_inc, seen_len;
    logic                                 r_fail, n_fail;
    logic                                 accept;
    t_base_dec                            dec;
    t_entry                               entry;
    logic signed [32:0]                   wext, wsat;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign dec        = decode_base(i_in.base_char);
    assign seen_inc   = (&r_seen) ? r_seen : r_seen + 1'b1;
    assign seen_len   = POSITION_BITS'(i_len);
    assign wext       = 33'(i_in.weight_value);
    assign o_entry    = ENTRY_W'(entry);

    // newest base enters at the top entry
    always_comb begin
        for (int i = 0; i < MAX_MOTIF_LEN - 1; i++) begin
            win_sh[i] = r_win[i + 1];
        end
        win_sh[MAX_MOTIF_LEN-1] = dec.code;
    end

    always_comb begin
        if (wext > WMAX) begin
            wsat = WMAX;
        end else if (wext < WMIN) begin
            wsat = WMIN;
        end else begin
            wsat = wext;
        end
    end

    always_comb begin
        n_win       = r_win;
        n_seen      = r_seen;
        n_fail      = r_fail;
        o_push      = 1'b0;
        entry       = '0;
        entry.len   = i_len;
        entry.win   = win_sh;
        entry.waddr = {IDX_W'(i_in.weight_pos), i_in.weight_base};
        entry.wval  = wsat[WEIGHT_BITS-1:0];
        entry.pos   = HPOS_W'(seen_inc - seen_len);
        if (accept) begin
            case (i_in.func)
                FUNC_START: begin
                    n_win  = '0;
                    n_seen = '0;
                    n_fail = 1'b0;
                end
                FUNC_LOAD: begin
                    if (32'(i_in.weight_pos) < MAX_MOTIF_LEN) begin
                        o_push     = 1'b1;
                        entry.kind = KIND_LOAD;
                    end
                end
                FUNC_SCAN: begin
                    if (!r_fail) begin
                        if (!dec.ok) begin
                            n_fail     = 1'b1;
                            o_push     = 1'b1;
                            entry.kind = KIND_ERR;
                        end else begin
                            n_win  = win_sh;
                            n_seen = seen_inc;
                            if (seen_inc >= seen_len) begin
                                o_push     = 1'b1;
                                entry.kind = KIND_SCAN;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_seen <= '0;
            r_fail <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_seen <= n_seen;
            r_fail <= n_fail;
        end
    end

endmodule

### sv/pwmsc_back.sv
// pwmsc_back: weight table, window score sequencer and result register
// depends on pwmsc_pkg and pwmsc_if; drains pwmsc_queue

module pwmsc_back #(
    parameter int MAX_MOTIF_LEN = pwmsc_pkg::MAX_MOTIF_LEN_DEF,
    parameter int WEIGHT_BITS   = pwmsc_pkg::WEIGHT_BITS_DEF,
    parameter int LEN_W         = $clog2(MAX_MOTIF_LEN + 1),
    parameter int ENTRY_W       = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ENTRY_W-1:0]                  i_entry,
    input  logic                                i_empty,
    output logic                                o_pop,
    input  logic signed [pwmsc_pkg::SCORE_W-1:0] i_threshold,
    pwmsc_out_if.source                         o_out
);
    import pwmsc_pkg::*;

    localparam int IDX_W = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int ABITS = IDX_W + BASE_W;
    localparam int ACC_W = WEIGHT_BITS + IDX_W + 1;
    localparam logic signed [63:0] SMAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SMIN = -64'sh0000_0000_8000_0000;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_SAT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]                     kind;
        logic [LEN_W-1:0]                      len;
        logic [HPOS_W-1:0]                     pos;
        logic [MAX_MOTIF_LEN-1:0][BASE_W-1:0] win;
        logic [ABITS-1:0]                      waddr;
        logic [WEIGHT_BITS-1:0]                wval;
    } t_entry;

    logic signed [WEIGHT_BITS-1:0]        r_mem [MAX_MOTIF_LEN*4];
    logic [2:0]                           r_state, n_state;
    logic                                 r_rd_vld;
    logic                                 r_ov, n_ov;
    logic [MAX_MOTIF_LEN-1:0][BASE_W-1:0] r_win;
    logic [LEN_W-1:0]                     r_len;
    logic [HPOS_W-1:0]                    r_pos;
    logic [IDX_W-1:0]                     r_j, r_idx;
    logic signed [ACC_W-1:0]              r_acc;
    logic signed [WEIGHT_BITS-1:0]        r_rd;
    logic signed [SCORE_W-1:0]            r_score;
    logic                                 r_err;
    logic                                 r_oerr;
    logic [HPOS_W-1:0]                    r_opos;
    logic signed [SCORE_W-1:0]            r_oscore;
    t_entry                               head;
    logic [ABITS-1:0]                     rd_addr;
    logic                                 out_free;
    logic                                 emit_hit;
    logic                                 last_step;
    logic signed [63:0]                   acc64;
    logic signed [SCORE_W-1:0]            sat;

    assign head      = t_entry'(i_entry);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign out_free  = !r_ov || o_out.ready;
    assign emit_hit  = r_err || (r_score >= i_threshold);
    assign rd_addr   = {r_j, r_win[r_idx]};
    assign last_step = (r_j == IDX_W'(r_len - LEN_W'(1)));
    assign acc64     = 64'(r_acc);
    assign sat       = (acc64 > SMAX) ? SCORE_W'(SMAX) :
                       (acc64 < SMIN) ? SCORE_W'(SMIN) : SCORE_W'(acc64);

    assign o_out.valid        = r_ov;
    assign o_out.is_error     = r_oerr;
    assign o_out.hit_position = r_opos;
    assign o_out.hit_score    = r_oscore;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    case (head.kind)
                        KIND_SCAN: n_state = S_READ;
                        KIND_ERR:  n_state = S_EMIT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (last_step) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_SAT;
            S_SAT:  n_state = S_EMIT;
            S_EMIT: begin
                if (!emit_hit || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_state == S_EMIT && emit_hit && out_free) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_READ);
            r_ov     <= n_ov;
        end
    end

    // weight table
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (o_pop && head.kind == KIND_LOAD) begin
            r_mem[head.waddr] <= head.wval;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_win   <= head.win;
                    r_len   <= head.len;
                    r_pos   <= head.pos;
                    r_j     <= '0;
                    r_idx   <= IDX_W'(LEN_W'(MAX_MOTIF_LEN) - head.len);
                    r_acc   <= '0;
                    r_score <= '0;
                    r_err   <= (head.kind == KIND_ERR);
                end
            end
            S_READ: begin
                r_j   <= r_j + 1'b1;
                r_idx <= r_idx + 1'b1;
                if (r_rd_vld) begin
                    r_acc <= r_acc + ACC_W'(r_rd);
                end
            end
            S_LAST: r_acc <= r_acc + ACC_W'(r_rd);
            S_SAT:  r_score <= sat;
            S_EMIT: begin
                if (emit_hit && out_free) begin
                    r_oerr   <= r_err;
                    r_opos   <= r_err ? '0 : r_pos;
                    r_oscore <= r_score;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/pwm_motif_scanner.sv
// pwm_motif_scanner: position weight matrix motif scan over a DNA base stream
// Channels: i_in takes words (func scan/load/start with base_char or weight
// fields), o_out gives result words (hit or error), i_cfg writes
// motif_length (index 0) and score_threshold (index 1); i_cfg is always ready.
// A scan word is decoded combinationally in the front part; loads and scan
// windows that may hit go through a 4-entry queue to the back part, which
// adds motif_length weights, one weight table read per cycle.
// A window passes the states S_READ, S_LAST, S_SAT and S_EMIT; the back part
// pops a new entry only in S_IDLE, so it ends one window before the next,
// and writes a load to the weight table as it pops it. Starts, short-sequence
// bases and bases after an error stay in the front part. i_in accepts a word
// every cycle while the queue has room.
// Reset (synchronous, i_rst_n low) clears window, position count, error
// flag, queue and output valid, and sets motif_length 1, threshold 0; the
// weight table keeps its contents and must be loaded before use.
// When o_out is stalled the result word holds; the back part waits with its
// next result and the queue, then i_in.ready, fill behind it.
// Depends on pwmsc_pkg, pwmsc_if, pwmsc_queue, pwmsc_front, pwmsc_back.

module pwm_motif_scanner #(
    parameter int MAX_MOTIF_LEN = pwmsc_pkg::MAX_MOTIF_LEN_DEF,
    parameter int WEIGHT_BITS   = pwmsc_pkg::WEIGHT_BITS_DEF,
    parameter int POSITION_BITS = pwmsc_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pwmsc_in_if.sink    i_in,
    pwmsc_out_if.source o_out,
    pwmsc_cfg_if.sink   i_cfg
);
    import pwmsc_pkg::*;

    localparam int LEN_W   = $clog2(MAX_MOTIF_LEN + 1);
    localparam int IDX_W   = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int ENTRY_W = KIND_W + LEN_W + HPOS_W + BASE_W * MAX_MOTIF_LEN
                             + IDX_W + BASE_W + WEIGHT_BITS;

    logic [MLEN_W-1:0]         r_mlen;
    logic signed [SCORE_W-1:0] r_thr;
    logic [LEN_W-1:0]          len;
    logic                      push, full, pop, empty;
    logic [ENTRY_W-1:0]        q_in, q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mlen <= MLEN_W'(1);
            r_thr  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MOTIF_LEN: r_mlen <= i_cfg.data[MLEN_W-1:0];
                REG_THRESHOLD: r_thr  <= $signed(i_cfg.data[SCORE_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_mlen == '0) begin
            len = LEN_W'(1);
        end else if (32'(r_mlen) > MAX_MOTIF_LEN) begin
            len = LEN_W'(MAX_MOTIF_LEN);
        end else begin
            len = LEN_W'(r_mlen);
        end
    end

    pwmsc_front #(
        .MAX_MOTIF_LEN (MAX_MOTIF_LEN),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .POSITION_BITS (POSITION_BITS),
        .LEN_W         (LEN_W),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_len   (len),
        .o_push  (push),
        .o_entry (q_in),
        .i_full  (full)
    );

    pwmsc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    pwmsc_back #(
        .MAX_MOTIF_LEN (MAX_MOTIF_LEN),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .LEN_W         (LEN_W),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_threshold (r_thr),
        .o_out       (o_out)
    );

endmodule

### sv/pwmsc_checker.sv
// pwmsc_checker: port-level checks of the motif scanner result channel
// depends on pwmsc_pkg; bound to pwm_motif_scanner below

module pwmsc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic                                i_is_error,
    input logic [pwmsc_pkg::HPOS_W-1:0]        i_hit_position,
    input logic signed [pwmsc_pkg::SCORE_W-1:0] i_hit_score
);
    import pwmsc_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // error word carries no position and no score
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_error) |-> (i_hit_position == '0 && i_hit_score == '0))
        else $error("error word with nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_is_error) && $stable(i_hit_position)
             && $stable(i_hit_score)))
        else $error("result word changed while stalled");

    // a valid result word carries no unknown bits
    a_known_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_is_error, i_hit_position, i_hit_score}))
        else $error("result word has unknown bits");

endmodule

bind pwm_motif_scanner pwmsc_checker u_pwmsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_is_error     (o_out.is_error),
    .i_hit_position (o_out.hit_position),
    .i_hit_score    (o_out.hit_score)
);
